// ----- src/rprop_weight_update_assert.svh -----
// Assertion macros used by rprop_weight_update.
`ifndef RPROP_WEIGHT_UPDATE_ASSERT_SVH
`define RPROP_WEIGHT_UPDATE_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define RWU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define RWU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rwu_pkg.sv -----
package rwu_pkg;

    localparam int IDX_W        = 12;
    localparam int WEIGHT_W     = 32;
    localparam int STEP_W       = 31;
    localparam int SIGN_W       = 2;
    localparam int ELEMENTS_DEF = 4096;
    localparam int FRAC_BITS    = 24;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_FLOOR   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_CEILING = 1'b1;

    localparam logic [STEP_W-1:0] STEP_FLOOR_RST = 31'd17;
    localparam logic [STEP_W-1:0] STEP_CEIL_RST  = 31'd838860800;
    localparam logic [STEP_W-1:0] STEP_TENTH =
        STEP_W'(((64'd1 << (FRAC_BITS + 1)) + 64'd10) / 64'd20);

    localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
    localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
    localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

    // floor(step / 5) as (step * ceil(2^34 / 5)) >> 34, exact for 32-bit operands
    localparam int FIFTH_SH = 34;
    localparam logic [31:0] FIFTH_MUL = 32'hCCCC_CCCD;
    localparam int FIFTH_W = STEP_W + 32 - FIFTH_SH;

    typedef struct packed {
        logic [IDX_W-1:0]           element_index;
        logic signed [WEIGHT_W-1:0] current_weight;
        logic signed [WEIGHT_W-1:0] gradient;
    } rwu_in_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] new_weight;
        logic [STEP_W-1:0]          new_step;
        logic                       reverted;
    } rwu_out_t;

    typedef struct packed {
        logic [SIGN_W-1:0]          sign;
        logic [STEP_W-1:0]          step;
        logic signed [WEIGHT_W-1:0] change;
    } rwu_entry_t;

    localparam rwu_entry_t ENTRY_RST = '{
        sign:   SIGN_POS,
        step:   STEP_TENTH,
        change: $signed({1'b0, STEP_TENTH})
    };

endpackage

// ----- src/rwu_ram.sv -----
module rwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the address being written returns the old word
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rwu_update.sv -----
module rwu_update (
    input  rwu_pkg::rwu_entry_t                   entry,
    input  logic [rwu_pkg::FIFTH_W-1:0]           step_fifth,
    input  logic [rwu_pkg::SIGN_W-1:0]            grad_sign,
    input  logic signed [rwu_pkg::WEIGHT_W-1:0]   weight,
    input  logic [rwu_pkg::STEP_W-1:0]            step_floor,
    input  logic [rwu_pkg::STEP_W-1:0]            step_ceiling,
    output rwu_pkg::rwu_entry_t                   new_entry,
    output rwu_pkg::rwu_out_t                     result
);
    import rwu_pkg::*;

    function automatic logic signed [WEIGHT_W-1:0] sat_w(input logic signed [WEIGHT_W:0] v);
        logic signed [WEIGHT_W-1:0] r;
        if (v[WEIGHT_W] != v[WEIGHT_W-1]) begin
            r = v[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end else begin
            r = v[WEIGHT_W-1:0];
        end
        return r;
    endfunction

    logic                       both_nz;
    logic                       grow;
    logic                       shrink;
    logic [STEP_W:0]            grown;
    logic [STEP_W-1:0]          halved;
    logic [STEP_W-1:0]          step_new;
    logic signed [WEIGHT_W:0]   step_ext;
    logic signed [WEIGHT_W:0]   change_ext;
    logic signed [WEIGHT_W:0]   last_ext;
    logic signed [WEIGHT_W:0]   weight_ext;
    logic signed [WEIGHT_W:0]   sum_ext;

    always_comb begin
        both_nz = (grad_sign != SIGN_ZERO) && (entry.sign != SIGN_ZERO);
        grow    = both_nz && (grad_sign == entry.sign);
        shrink  = both_nz && (grad_sign != entry.sign);
        grown   = {1'b0, entry.step} + (STEP_W+1)'(step_fifth);
        halved  = {1'b0, entry.step[STEP_W-1:1]};

        if (grow) begin
            step_new = (grown > {1'b0, step_ceiling}) ? step_ceiling : grown[STEP_W-1:0];
        end else if (shrink) begin
            step_new = (halved < step_floor) ? step_floor : halved;
        end else begin
            step_new = entry.step;
        end

        step_ext = $signed({2'b00, step_new});
        case (grad_sign)
            SIGN_POS: change_ext = -step_ext;
            SIGN_NEG: change_ext = step_ext;
            default:  change_ext = '0;
        endcase

        last_ext   = {entry.change[WEIGHT_W-1], entry.change};
        weight_ext = {weight[WEIGHT_W-1], weight};
        sum_ext    = shrink ? (weight_ext - last_ext) : (weight_ext + change_ext);

        new_entry.sign   = shrink ? SIGN_ZERO : grad_sign;
        new_entry.step   = step_new;
        new_entry.change = shrink ? sat_w(-last_ext) : change_ext[WEIGHT_W-1:0];

        result.new_weight = sat_w(sum_ext);
        result.new_step   = step_new;
        result.reverted   = shrink;
    end

endmodule

// ----- src/rprop_weight_update.sv -----
// Rprop+ per-weight update with weight backtracking.
// s_ channel: one transaction per weight (index, present weight, gradient).
// m_ channel: one transaction per input (new weight, new step, reverted flag),
// in input order. cfg_wr_en/cfg_addr/cfg_wdata write step_floor (0) and
// step_ceiling (1); write them only while no transaction is in flight.
// Stages: p1 wrap multiply, p2 remainder and state read, p3 step fifth,
// p4 update and write-back, then the output register. Throughput:
// 1 transaction per cycle. Per-weight state sits in one RAM, read as a
// transaction leaves p2 and written back as it leaves p4; an address equal
// to one in p3 or p4 waits in p2 until that write-back is done.
// Index wrap modulo ELEMENTS uses a two-stage reciprocal multiply.
// Reset: config registers return to defaults, then a clear pass writes the
// reset entry into every RAM word, with s_ready held low throughout.
// Stall: the output register holds its transaction until m_ready; stages
// behind it keep filling; s_ready drops when p1 is held, by a full pipe or a hazard.
`include "rprop_weight_update_assert.svh"

module rprop_weight_update #(
    parameter int ELEMENTS = rwu_pkg::ELEMENTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rwu_pkg::rwu_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rwu_pkg::rwu_out_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [rwu_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rwu_pkg::STEP_W-1:0]         cfg_wdata
);
    import rwu_pkg::*;

    localparam int ADDR_W  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int WRAP_SH = 2 * IDX_W;
    localparam int WRAP_PW = IDX_W + WRAP_SH + 1;
    localparam logic [WRAP_SH:0] WRAP_MUL = (ELEMENTS <= (1 << IDX_W)) ?
        (WRAP_SH+1)'(((1 << WRAP_SH) + ELEMENTS - 1) / ELEMENTS) : '0;
    localparam int REM_W   = IDX_W + ADDR_W + 1;
    localparam int ENTRY_W = $bits(rwu_entry_t);

    logic [STEP_W-1:0] step_floor_reg;
    logic [STEP_W-1:0] step_ceiling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_floor_reg   <= STEP_FLOOR_RST;
            step_ceiling_reg <= STEP_CEIL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STEP_FLOOR:   step_floor_reg   <= cfg_wdata;
                REG_STEP_CEILING: step_ceiling_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [ADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic              clear_done_reg, clear_done_next;

    always_comb begin
        clear_cnt_next  = clear_cnt_reg;
        clear_done_next = clear_done_reg;
        if (!clear_done_reg) begin
            if (clear_cnt_reg == ADDR_W'(ELEMENTS - 1)) begin
                clear_done_next = 1'b1;
            end else begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_cnt_reg  <= '0;
            clear_done_reg <= 1'b0;
        end else begin
            clear_cnt_reg  <= clear_cnt_next;
            clear_done_reg <= clear_done_next;
        end
    end

    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, m_valid_reg;
    logic out_free, p4_go, p4_can, p3_go, p3_can, p2_go, p2_can, p1_go, p1_can;
    logic s_fire, hazard;

    logic [IDX_W-1:0]           p1_idx_reg;
    logic signed [WEIGHT_W-1:0] p1_weight_reg;
    logic [SIGN_W-1:0]          p1_gs_reg;
    logic [SIGN_W-1:0]          s_gs;

    logic [IDX_W-1:0]           p2_idx_reg;
    logic [IDX_W-1:0]           p2_q_reg;
    logic signed [WEIGHT_W-1:0] p2_weight_reg;
    logic [SIGN_W-1:0]          p2_gs_reg;

    logic [ADDR_W-1:0]          p3_addr_reg;
    logic signed [WEIGHT_W-1:0] p3_weight_reg;
    logic [SIGN_W-1:0]          p3_gs_reg;

    rwu_entry_t                 p4_entry_reg;
    logic [FIFTH_W-1:0]         p4_fifth_reg;
    logic [ADDR_W-1:0]          p4_addr_reg;
    logic signed [WEIGHT_W-1:0] p4_weight_reg;
    logic [SIGN_W-1:0]          p4_gs_reg;

    rwu_out_t                   m_data_reg;

    logic [WRAP_PW-1:0]         wrap_prod;
    logic [REM_W-1:0]           wrap_rem;
    logic [ADDR_W-1:0]          p2_addr;
    logic [ENTRY_W-1:0]         ram_rdata;
    rwu_entry_t                 p3_entry;
    logic [STEP_W+31:0]         fifth_prod;
    rwu_entry_t                 upd_entry;
    rwu_out_t                   upd_result;

    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    rwu_entry_t                 ram_wdata;

    assign out_free = !m_valid_reg || m_ready;
    assign p4_go    = p4_v_reg && out_free;
    assign p4_can   = !p4_v_reg || p4_go;
    assign p3_go    = p3_v_reg && p4_can;
    assign p3_can   = !p3_v_reg || p3_go;
    assign hazard   = (p3_v_reg && (p3_addr_reg == p2_addr)) ||
                      (p4_v_reg && (p4_addr_reg == p2_addr));
    assign p2_go    = p2_v_reg && !hazard && p3_can;
    assign p2_can   = !p2_v_reg || p2_go;
    assign p1_go    = p1_v_reg && p2_can;
    assign p1_can   = !p1_v_reg || p1_go;
    assign s_ready  = clear_done_reg && p1_can;
    assign s_fire   = s_valid && s_ready;

    always_comb begin
        if (s_data.gradient == '0) begin
            s_gs = SIGN_ZERO;
        end else if (s_data.gradient[WEIGHT_W-1]) begin
            s_gs = SIGN_NEG;
        end else begin
            s_gs = SIGN_POS;
        end
    end

    assign wrap_prod  = WRAP_PW'(p1_idx_reg) * WRAP_PW'(WRAP_MUL);
    assign wrap_rem   = REM_W'(p2_idx_reg) - REM_W'(p2_q_reg) * REM_W'(ELEMENTS);
    assign p2_addr    = wrap_rem[ADDR_W-1:0];
    assign p3_entry   = rwu_entry_t'(ram_rdata);
    assign fifth_prod = (STEP_W+32)'(p3_entry.step) * (STEP_W+32)'(FIFTH_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            p3_v_reg    <= 1'b0;
            p4_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (p1_can) begin
                p1_v_reg <= s_fire;
            end
            if (p2_can) begin
                p2_v_reg <= p1_go;
            end
            if (p3_can) begin
                p3_v_reg <= p2_go;
            end
            if (p4_can) begin
                p4_v_reg <= p3_go;
            end
            if (out_free) begin
                m_valid_reg <= p4_go;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_idx_reg    <= s_data.element_index;
            p1_weight_reg <= s_data.current_weight;
            p1_gs_reg     <= s_gs;
        end
        if (p1_go) begin
            p2_idx_reg    <= p1_idx_reg;
            p2_q_reg      <= wrap_prod[WRAP_SH +: IDX_W];
            p2_weight_reg <= p1_weight_reg;
            p2_gs_reg     <= p1_gs_reg;
        end
        if (p2_go) begin
            p3_addr_reg   <= p2_addr;
            p3_weight_reg <= p2_weight_reg;
            p3_gs_reg     <= p2_gs_reg;
        end
        if (p3_go) begin
            p4_entry_reg  <= p3_entry;
            p4_fifth_reg  <= fifth_prod[FIFTH_SH +: FIFTH_W];
            p4_addr_reg   <= p3_addr_reg;
            p4_weight_reg <= p3_weight_reg;
            p4_gs_reg     <= p3_gs_reg;
        end
        if (p4_go) begin
            m_data_reg <= upd_result;
        end
    end

    rwu_update u_update (
        .entry        (p4_entry_reg),
        .step_fifth   (p4_fifth_reg),
        .grad_sign    (p4_gs_reg),
        .weight       (p4_weight_reg),
        .step_floor   (step_floor_reg),
        .step_ceiling (step_ceiling_reg),
        .new_entry    (upd_entry),
        .result       (upd_result)
    );

    assign ram_we    = !clear_done_reg || p4_go;
    assign ram_waddr = clear_done_reg ? p4_addr_reg : clear_cnt_reg;
    assign ram_wdata = clear_done_reg ? upd_entry : ENTRY_RST;

    rwu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ELEMENTS)
    ) u_state_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (p2_go),
        .raddr (p2_addr),
        .rdata (ram_rdata)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RWU_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, !clear_done_reg, !s_ready, "transaction accepted during clear pass")
    `RWU_ASSERT_NOW(a_clear_pipe_empty, aclk, aresetn, !clear_done_reg, (ram_we && !p1_v_reg && !p2_v_reg && !p3_v_reg && !p4_v_reg), "pipeline busy during clear pass")
    `RWU_ASSERT_NOW(a_no_rw_collision, aclk, aresetn, (ram_we && p2_go), (ram_waddr != p2_addr), "state read and write-back hit the same entry")
    `RWU_ASSERT_NEXT(a_result_lands, aclk, aresetn, p4_go, m_valid_reg, "write-back without result")

endmodule
